// File: design/fcfc_pkg.sv
// Package for the FAT chain fragment checker.
// Holds widths, request kinds, error codes and the sequencer state type.
package fcfc_pkg;
    localparam int FAT_BYTES = 16384;
    localparam int ADDR_W = $clog2(FAT_BYTES);

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_CHAIN = 2'd1;
    localparam logic [1:0] KIND_SCAN  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_UNALLOC = 2'd1;
    localparam logic [1:0] ERR_CROSS = 2'd2;
    localparam logic [1:0] ERR_BAD   = 2'd3;

    localparam logic [0:0] REG_WIDE  = 1'd0;
    localparam logic [0:0] REG_COUNT = 1'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] byte_addr;
        logic [7:0]  byte_value;
        logic [15:0] start_cluster;
    } t_req;

    typedef struct packed {
        logic [15:0] pieces;
        logic [1:0]  chain_error;
        logic [15:0] free_areas;
        logic [15:0] bad_areas;
        logic [15:0] lost_count;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CRD0, ST_CRD1, ST_CEVAL, ST_CWR1, ST_GRD0, ST_GRD1, ST_GEVAL,
        ST_SRD0, ST_SRD1, ST_SEVAL, ST_OUT
    } t_state;
endpackage

// File: design/fcfc_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing; the payload type is a parameter of the interface.
interface fcfc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/fat_chain_fragment_checker.sv
// Top level of the FAT chain fragment checker: byte memory and walk sequencer.
// Depends on fcfc_pkg and fcfc_if.
//
// channel   dir  payload
// i_req     in   kind, byte_addr, byte_value, start_cluster
// o_res     out  pieces, chain_error, free_areas, bad_areas, lost_count
//
// A chain link steps through CRD0 and CRD1, two byte reads through the single port of
// the FAT memory, CEVAL, which evaluates and also writes the low mark byte, and CWR1
// for the high mark byte. A forward gap steps through GRD0, GRD1 and GEVAL per bad
// cluster and GRD0 to close it; a scan steps through SRD0, SRD1 and SEVAL per cluster.
// One request at a time. Reset is synchronous; the FAT memory is not cleared. Results
// wait in a register until taken; the next request is taken only after that.
module fat_chain_fragment_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    fcfc_if.sink   i_req,
    fcfc_if.source o_res
);
    logic r_wide, n_wide;
    logic [15:0] r_count, n_count;
    fcfc_pkg::t_state r_st, n_st;

    logic [7:0] r_mem [fcfc_pkg::FAT_BYTES];
    logic [7:0] r_rd;
    logic [fcfc_pkg::ADDR_W-1:0] mem_addr;
    logic mem_we;
    logic [7:0] mem_wd;
    logic [17:0] base_addr, byte_addr;

    logic [15:0] r_n, n_n, r_nc, n_nc, r_j, n_j;
    logic [7:0] r_lo, n_lo;
    logic [7:0] r_hi, n_hi;
    logic [15:0] r_p, n_p;
    logic [1:0] r_err, n_err;
    logic [15:0] r_fr, n_fr, r_bd, n_bd, r_lost, n_lost;
    logic r_pf, n_pf, r_pb, n_pb;
    fcfc_pkg::t_res r_res, n_res;
    logic r_ovalid, n_ovalid;
    logic r_mark;

    logic [15:0] cur, entry, bad_code, end_code;
    logic [15:0] w16;
    logic [7:0] hi_rd;
    logic eval_st;
    logic is_bad, is_end, in_range;

    assign cur = (r_st == fcfc_pkg::ST_GRD0 || r_st == fcfc_pkg::ST_GRD1 ||
                  r_st == fcfc_pkg::ST_GEVAL) ? r_j : r_n;
    assign base_addr = r_wide ? {1'b0, cur, 1'b0}
                              : 18'(({2'b00, cur} + {1'b0, cur, 1'b0}) >> 1);
    assign eval_st = r_st == fcfc_pkg::ST_CEVAL || r_st == fcfc_pkg::ST_GEVAL ||
                     r_st == fcfc_pkg::ST_SEVAL;
    assign hi_rd = (base_addr + 18'd1 < 18'(fcfc_pkg::FAT_BYTES)) ? r_rd : 8'd0;
    assign w16 = {eval_st ? hi_rd : r_hi, r_lo};
    assign entry = r_wide ? w16 : (cur[0] ? {4'd0, w16[15:4]} : {4'd0, w16[11:0]});
    assign bad_code = r_wide ? 16'hfff7 : 16'h0ff7;
    assign end_code = r_wide ? 16'hfff0 : 16'h0ff0;
    assign is_bad = entry == bad_code;
    assign is_end = entry >= end_code && !is_bad;
    assign in_range = r_n >= 16'd2 && r_n < r_count;

    always_comb begin
        n_wide = r_wide;
        n_count = r_count;
        if (i_cfg_we) begin
            case (i_cfg_index)
                fcfc_pkg::REG_WIDE:  n_wide = i_cfg_data[0];
                fcfc_pkg::REG_COUNT: n_count = i_cfg_data;
                default: n_wide = r_wide;
            endcase
        end
    end

    assign i_req.ready = r_st == fcfc_pkg::ST_IDLE && !r_ovalid;
    assign o_res.valid = r_ovalid;
    assign o_res.payload = r_res;

    always_comb begin
        n_st = r_st;
        case (r_st)
            fcfc_pkg::ST_IDLE:
                if (i_req.valid && i_req.ready) begin
                    case (i_req.payload.kind)
                        fcfc_pkg::KIND_CHAIN: n_st = fcfc_pkg::ST_CRD0;
                        fcfc_pkg::KIND_SCAN:  n_st = fcfc_pkg::ST_SRD0;
                        default: n_st = fcfc_pkg::ST_IDLE;
                    endcase
                end
            fcfc_pkg::ST_CRD0:
                if (r_n == 16'd0) n_st = fcfc_pkg::ST_OUT;
                else if (!in_range) n_st = fcfc_pkg::ST_OUT;
                else n_st = fcfc_pkg::ST_CRD1;
            fcfc_pkg::ST_CRD1: n_st = fcfc_pkg::ST_CEVAL;
            fcfc_pkg::ST_CEVAL: begin
                if (entry == 16'd1) n_st = fcfc_pkg::ST_OUT;
                else n_st = fcfc_pkg::ST_CWR1;
            end
            fcfc_pkg::ST_CWR1: begin
                if (r_err != fcfc_pkg::ERR_OK || r_mark) n_st = fcfc_pkg::ST_OUT;
                else if (r_nc > r_n && r_n + 16'd1 != r_nc) n_st = fcfc_pkg::ST_GRD0;
                else n_st = fcfc_pkg::ST_CRD0;
            end
            fcfc_pkg::ST_GRD0:
                n_st = (r_j == r_nc) ? fcfc_pkg::ST_CRD0 : fcfc_pkg::ST_GRD1;
            fcfc_pkg::ST_GRD1: n_st = fcfc_pkg::ST_GEVAL;
            fcfc_pkg::ST_GEVAL: n_st = is_bad ? fcfc_pkg::ST_GRD0 : fcfc_pkg::ST_CRD0;
            fcfc_pkg::ST_SRD0:
                n_st = (r_n < r_count) ? fcfc_pkg::ST_SRD1 : fcfc_pkg::ST_OUT;
            fcfc_pkg::ST_SRD1: n_st = fcfc_pkg::ST_SEVAL;
            fcfc_pkg::ST_SEVAL: n_st = fcfc_pkg::ST_SRD0;
            fcfc_pkg::ST_OUT: n_st = fcfc_pkg::ST_IDLE;
            default: n_st = fcfc_pkg::ST_IDLE;
        endcase
    end

    // Mark data for the entry at cur: low byte in CEVAL, high byte in CWR1.
    logic [15:0] mark_w;
    assign mark_w = r_wide ? 16'h0001 :
                    (cur[0] ? ((w16 & 16'h000f) | 16'h0010) : ((w16 & 16'hf000) | 16'h0001));

    always_comb begin
        mem_we = 1'b0;
        mem_wd = 8'd0;
        byte_addr = base_addr;
        case (r_st)
            fcfc_pkg::ST_IDLE: begin
                byte_addr = {4'd0, i_req.payload.byte_addr};
                mem_we = i_req.valid && i_req.ready &&
                         i_req.payload.kind == fcfc_pkg::KIND_LOAD;
                mem_wd = i_req.payload.byte_value;
            end
            fcfc_pkg::ST_CRD1, fcfc_pkg::ST_GRD1, fcfc_pkg::ST_SRD1:
                byte_addr = base_addr + 18'd1;
            fcfc_pkg::ST_CEVAL: begin
                mem_we = entry != 16'd1;
                mem_wd = mark_w[7:0];
            end
            fcfc_pkg::ST_CWR1: begin
                byte_addr = base_addr + 18'd1;
                mem_we = 1'b1;
                mem_wd = mark_w[15:8];
            end
            default: byte_addr = base_addr;
        endcase
    end
    assign mem_addr = byte_addr[fcfc_pkg::ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we && byte_addr < 18'(fcfc_pkg::FAT_BYTES)) r_mem[mem_addr] <= mem_wd;
        r_rd <= r_mem[mem_addr];
    end

    always_comb begin
        n_n = r_n; n_nc = r_nc; n_j = r_j; n_lo = r_lo; n_hi = r_hi;
        n_p = r_p; n_err = r_err; n_fr = r_fr; n_bd = r_bd; n_lost = r_lost;
        n_pf = r_pf; n_pb = r_pb; n_res = r_res; n_ovalid = r_ovalid;
        if (o_res.valid && o_res.ready) n_ovalid = 1'b0;
        case (r_st)
            fcfc_pkg::ST_IDLE: begin
                n_n = (i_req.payload.kind == fcfc_pkg::KIND_SCAN) ? 16'd2
                      : i_req.payload.start_cluster;
                n_p = '0; n_err = fcfc_pkg::ERR_OK; n_fr = '0; n_bd = '0; n_lost = '0;
                n_pf = 1'b0; n_pb = 1'b0;
            end
            fcfc_pkg::ST_CRD0:
                if (r_n != 16'd0 && !in_range) n_err = fcfc_pkg::ERR_UNALLOC;
            fcfc_pkg::ST_CRD1, fcfc_pkg::ST_GRD1, fcfc_pkg::ST_SRD1:
                n_lo = (base_addr < 18'(fcfc_pkg::FAT_BYTES)) ? r_rd : 8'd0;
            fcfc_pkg::ST_CEVAL: begin
                n_hi = hi_rd;
                n_nc = entry;
                n_j = r_n + 16'd1;
                if (entry == 16'd0) n_err = fcfc_pkg::ERR_UNALLOC;
                else if (entry == 16'd1) n_err = fcfc_pkg::ERR_CROSS;
                else if (is_bad) n_err = fcfc_pkg::ERR_BAD;
                else if (!is_end && r_n + 16'd1 != entry) n_p = r_p + 16'd1;
            end
            fcfc_pkg::ST_CWR1: if (!r_mark) n_n = r_nc;
            fcfc_pkg::ST_GRD0: if (r_j == r_nc) n_p = r_p - 16'd1;
            fcfc_pkg::ST_GEVAL: begin
                if (is_bad) n_j = r_j + 16'd1;
            end
            fcfc_pkg::ST_SEVAL: begin
                if (entry == 16'd0 && !r_pf) n_fr = r_fr + 16'd1;
                if (is_bad && !r_pb) n_bd = r_bd + 16'd1;
                if (entry != 16'd0 && !is_bad && entry != 16'd1 && r_lost != 16'hffff)
                    n_lost = r_lost + 16'd1;
                n_pf = entry == 16'd0;
                n_pb = is_bad;
                n_n = r_n + 16'd1;
            end
            fcfc_pkg::ST_OUT: begin
                n_ovalid = 1'b1;
                n_res.pieces = (r_err == fcfc_pkg::ERR_OK) ? r_p : 16'd0;
                n_res.chain_error = r_err;
                n_res.free_areas = r_fr;
                n_res.bad_areas = r_bd;
                n_res.lost_count = r_lost;
            end
            default: n_n = r_n;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= fcfc_pkg::ST_IDLE;
            r_wide <= 1'b0;
            r_count <= 16'd2;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_wide <= n_wide;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_nc <= n_nc; r_j <= n_j; r_lo <= n_lo; r_hi <= n_hi; r_p <= n_p;
        r_err <= n_err; r_fr <= n_fr; r_bd <= n_bd; r_lost <= n_lost;
        r_pf <= n_pf; r_pb <= n_pb; r_res <= n_res;
        r_mark <= (n_err != fcfc_pkg::ERR_OK) || (r_st == fcfc_pkg::ST_CEVAL && is_end);
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_res.ready |=> r_ovalid && $stable(r_res))
        else $error("result lost while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> r_st == fcfc_pkg::ST_IDLE)
        else $error("request taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == fcfc_pkg::ST_OUT |=> r_ovalid)
        else $error("result not posted");
endmodule

// File: tb/fat_chain_fragment_checker_tb.sv
// Self-checking bench for the FAT chain fragment checker: loads images, walks chains, scans.
// Depends on fcfc_pkg, fcfc_if and the fat_chain_fragment_checker top level.
`timescale 1ns / 1ps
module fat_chain_fragment_checker_tb;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    fcfc_if #(.T(fcfc_pkg::t_req)) req_ch ();
    fcfc_if #(.T(fcfc_pkg::t_res)) res_ch ();

    fat_chain_fragment_checker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req(req_ch.sink), .o_res(res_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // image as the block holds it at accept time, and as queued loads leave it
    logic [7:0] img [fcfc_pkg::FAT_BYTES];
    logic [7:0] q_img [fcfc_pkg::FAT_BYTES];
    bit         mdl_wide;
    int unsigned mdl_count;

    fcfc_pkg::t_req pending_reqs [$];
    fcfc_pkg::t_res expected_res [$];
    int   n_errors = 0;
    int   n_chains = 0;
    int   n_scans = 0;
    int   n_loads = 0;
    bit   hold_go = 1'b0;
    bit   hold_rx = 1'b0;
    bit   rx_random = 1'b1;

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
        n_errors++;
    endtask

    function automatic int unsigned get_byte(input int unsigned a);
        return (a < fcfc_pkg::FAT_BYTES) ? img[a] : 0;
    endfunction

    function automatic void put_byte(input int unsigned a, input int unsigned v);
        if (a < fcfc_pkg::FAT_BYTES) img[a] = v[7:0];
    endfunction

    function automatic int unsigned q_get(input int unsigned a);
        return (a < fcfc_pkg::FAT_BYTES) ? q_img[a] : 0;
    endfunction

    function automatic void q_put(input int unsigned a, input int unsigned v);
        if (a < fcfc_pkg::FAT_BYTES) q_img[a] = v[7:0];
    endfunction

    function automatic int unsigned fat_entry(input int unsigned c);
        int unsigned w;
        if (mdl_wide) return get_byte(2 * c) | (get_byte(2 * c + 1) << 8);
        w = get_byte((3 * c) >> 1) | (get_byte(((3 * c) >> 1) + 1) << 8);
        return c[0] ? (w >> 4) : (w & 32'hfff);
    endfunction

    function automatic void mark_cluster(input int unsigned c);
        int unsigned a, w;
        if (mdl_wide) begin
            put_byte(2 * c, 1);
            put_byte(2 * c + 1, 0);
            return;
        end
        a = (3 * c) >> 1;
        w = get_byte(a) | (get_byte(a + 1) << 8);
        if (c[0]) w = (w & 32'h000f) | 32'h0010;
        else w = (w & 32'hf000) | 32'h0001;
        put_byte(a, w & 8'hff);
        put_byte(a + 1, (w >> 8) & 8'hff);
    endfunction

    function automatic bit bad_code(input int unsigned v);
        return v == (mdl_wide ? 32'hfff7 : 32'hff7);
    endfunction

    function automatic bit end_code(input int unsigned v);
        return v >= (mdl_wide ? 32'hfff0 : 32'hff0) && !bad_code(v);
    endfunction

    function automatic fcfc_pkg::t_res predict_result(input fcfc_pkg::t_req r);
        fcfc_pkg::t_res o;
        int unsigned n, p, e, v, j, f, b, l;
        bit pf, pb, nf, nb;
        o = '0;
        if (r.kind == fcfc_pkg::KIND_CHAIN) begin
            n = r.start_cluster; p = 0; e = fcfc_pkg::ERR_OK;
            while (n != 0) begin
                if (n < 2 || n >= mdl_count) begin e = fcfc_pkg::ERR_UNALLOC; break; end
                v = fat_entry(n);
                if (v == 0) begin mark_cluster(n); e = fcfc_pkg::ERR_UNALLOC; break; end
                if (v == 1) begin e = fcfc_pkg::ERR_CROSS; break; end
                mark_cluster(n);
                if (end_code(v)) break;
                if (bad_code(v)) begin e = fcfc_pkg::ERR_BAD; break; end
                if (n + 1 != v) begin
                    p++;
                    if (v > n) begin
                        j = n + 1;
                        while (j < v && bad_code(fat_entry(j))) j++;
                        if (j == v) p--;
                    end
                end
                n = v;
            end
            o.pieces = e ? 16'd0 : p[15:0];
            o.chain_error = e[1:0];
        end else begin
            f = 0; b = 0; l = 0; pf = 0; pb = 0;
            for (int unsigned i = 2; i < mdl_count; i++) begin
                v = fat_entry(i);
                nf = (v == 0);
                nb = bad_code(v);
                if (nf && !pf) f++;
                if (nb && !pb) b++;
                if (!nf && !nb && v != 1 && l < 32'hffff) l++;
                pf = nf; pb = nb;
            end
            o.free_areas = f[15:0];
            o.bad_areas = b[15:0];
            o.lost_count = l[15:0];
        end
        return o;
    endfunction

    // driver
    int tx_wait = 0;
    int n_sent = 0;
    int n_taken = 0;
    initial begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
    end
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid) begin
                if (n_taken == n_sent) begin
                    req_ch.valid <= 1'b0;
                    tx_wait = $urandom_range(0, 14);
                    if (($urandom & 3) == 0) tx_wait = 0;
                end
            end else if (tx_wait > 0) tx_wait--;
            else if (pending_reqs.size() > 0) begin
                req_ch.payload <= pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                n_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            n_taken++;
            if (req_ch.payload.kind == fcfc_pkg::KIND_LOAD) begin
                put_byte(req_ch.payload.byte_addr, req_ch.payload.byte_value);
                n_loads++;
            end else if (req_ch.payload.kind == fcfc_pkg::KIND_CHAIN ||
                         req_ch.payload.kind == fcfc_pkg::KIND_SCAN) begin
                expected_res.push_back(predict_result(req_ch.payload));
                if (req_ch.payload.kind == fcfc_pkg::KIND_CHAIN) n_chains++;
                else n_scans++;
            end
        end
    end

    // monitor
    int rx_wait = 0;
    int rx_seen = 0;
    int n_got = 0;
    initial res_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (hold_rx) res_ch.ready <= 1'b0;
        else if (rx_seen != n_got) begin
            rx_seen = n_got;
            rx_wait = rx_random ? $urandom_range(0, 14) : 0;
            res_ch.ready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            res_ch.ready <= (rx_wait == 0);
        end else res_ch.ready <= 1'b1;
    end

    initial begin : rx_hold
        wait (hold_go);
        hold_rx = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_rx = 1'b0;
    end

    always @(posedge i_clk) begin
        fcfc_pkg::t_res exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_got++;
            if (expected_res.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                exp_r = expected_res.pop_front();
                if (res_ch.payload.pieces !== exp_r.pieces)
                    report_mismatch("pieces", res_ch.payload.pieces, exp_r.pieces);
                if (res_ch.payload.chain_error !== exp_r.chain_error)
                    report_mismatch("chain_error", res_ch.payload.chain_error,
                                    exp_r.chain_error);
                if (res_ch.payload.free_areas !== exp_r.free_areas)
                    report_mismatch("free_areas", res_ch.payload.free_areas,
                                    exp_r.free_areas);
                if (res_ch.payload.bad_areas !== exp_r.bad_areas)
                    report_mismatch("bad_areas", res_ch.payload.bad_areas, exp_r.bad_areas);
                if (res_ch.payload.lost_count !== exp_r.lost_count)
                    report_mismatch("lost_count", res_ch.payload.lost_count,
                                    exp_r.lost_count);
            end
        end
    end

    function automatic fcfc_pkg::t_req mk_req(input logic [1:0] k, input int unsigned a,
                                              input int unsigned v, input int unsigned s);
        fcfc_pkg::t_req r;
        r.kind = k; r.byte_addr = a[13:0]; r.byte_value = v[7:0]; r.start_cluster = s[15:0];
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val[15:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == fcfc_pkg::REG_WIDE) mdl_wide = val[0]; else mdl_count = val[15:0];
    endtask

    // queue an entry write as byte loads, keeping neighbors as queued
    task automatic set_entry(input int unsigned c, input int unsigned v);
        int unsigned a, w;
        if (mdl_wide) begin
            pending_reqs.push_back(mk_req(fcfc_pkg::KIND_LOAD, 2 * c, v & 8'hff, $urandom));
            pending_reqs.push_back(mk_req(fcfc_pkg::KIND_LOAD, 2 * c + 1, (v >> 8) & 8'hff,
                                          $urandom));
            q_put(2 * c, v & 8'hff); q_put(2 * c + 1, (v >> 8) & 8'hff);
        end else begin
            a = (3 * c) >> 1;
            w = q_get(a) | (q_get(a + 1) << 8);
            if (c[0]) w = (w & 32'h000f) | ((v & 32'hfff) << 4);
            else w = (w & 32'hf000) | (v & 32'hfff);
            pending_reqs.push_back(mk_req(fcfc_pkg::KIND_LOAD, a, w & 8'hff, $urandom));
            pending_reqs.push_back(mk_req(fcfc_pkg::KIND_LOAD, a + 1, (w >> 8) & 8'hff,
                                          $urandom));
            q_put(a, w & 8'hff); q_put(a + 1, (w >> 8) & 8'hff);
        end
    endtask

    // fill image with zero bytes covering clusters below cnt
    task automatic clear_image(input int unsigned cnt);
        int unsigned nb;
        nb = mdl_wide ? 2 * cnt + 2 : (3 * cnt) / 2 + 2;
        if (nb > fcfc_pkg::FAT_BYTES) nb = fcfc_pkg::FAT_BYTES;
        for (int unsigned i = 0; i < nb; i++) begin
            pending_reqs.push_back(mk_req(fcfc_pkg::KIND_LOAD, i, 0, $urandom));
            q_img[i] = 0;
        end
    endtask

    function automatic int unsigned rand_entry(input int unsigned cnt);
        int unsigned mx;
        mx = mdl_wide ? 16'hffff : 12'hfff;
        case ($urandom_range(0, 9))
            0, 1: return 0;
            2: return 1;
            3: return mdl_wide ? 16'hfff7 : 12'hff7;
            4: return mdl_wide ? $urandom_range(16'hfff0, 16'hffff)
                               : $urandom_range(12'hff0, 12'hfff);
            9: return $urandom_range(0, mx);
            default: return $urandom_range(0, cnt + 1);
        endcase
    endfunction

    // random chain with random gaps, bad fills and a random terminal
    task automatic build_chain(input int unsigned cnt, output int unsigned st);
        int unsigned c, nx, len, bc, ec;
        bc = mdl_wide ? 16'hfff7 : 12'hff7;
        ec = mdl_wide ? 16'hffff : 12'hfff;
        st = $urandom_range(2, cnt - 1);
        c = st;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 5))
                0, 1: nx = c + 1;
                2: begin
                    nx = c + $urandom_range(2, 4);
                    for (int unsigned j = c + 1; j < nx && j < cnt; j++) set_entry(j, bc);
                end
                default: nx = $urandom_range(2, cnt - 1);
            endcase
            if (nx >= cnt || nx == c) break;
            set_entry(c, nx);
            c = nx;
        end
        case ($urandom_range(0, 7))
            0: set_entry(c, 0);
            1: set_entry(c, bc);
            2: set_entry(c, cnt + $urandom_range(0, 3));
            default: set_entry(c, ec - $urandom_range(0, 6) == bc ? ec
                                                               : ec - $urandom_range(0, 6));
        endcase
    endtask

    int unsigned counts [6] = '{3, 5, 12, 40, 100, 200};

    initial begin : stimulus
        int unsigned cnt, st, items;
        fcfc_pkg::t_req r;
        mdl_wide = 0; mdl_count = 2;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty chain, count=2 scan, extremes
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, 16383, 255, 0));
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_SCAN, 0, 0, 0));
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, 0, 0, 16'hffff));
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, 0, 0, 1));
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_NONE, 16383, 255, 16'hffff));
        wait_drained();
        write_reg(fcfc_pkg::REG_COUNT, 12);
        clear_image(12);
        set_entry(2, 3); set_entry(3, 6); set_entry(4, 12'hff7); set_entry(5, 12'hff7);
        set_entry(6, 9); set_entry(9, 12'hfff); set_entry(10, 12'hff0); set_entry(11, 1);
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, 0, 0, 2));
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, 0, 0, 2));
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, 0, 0, 7));
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, 0, 0, 4));
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_SCAN, 0, 0, 0));
        wait_drained();
        write_reg(fcfc_pkg::REG_WIDE, 1);
        clear_image(12);
        set_entry(2, 16'hfff7); set_entry(3, 8); set_entry(8, 16'hfff0); set_entry(5, 16'h8000);
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, 0, 0, 3));
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, 0, 0, 5));
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_SCAN, 0, 0, 0));
        wait_drained();

        // backpressure: stall receiver while sender keeps offering
        for (int k = 0; k < 6; k++)
            pending_reqs.push_back(mk_req(fcfc_pkg::KIND_SCAN, 0, 0, 0));
        hold_go = 1'b1;
        wait (hold_rx);
        wait (!hold_rx);
        wait_drained();

        items = 0;
        while (items < 1300) begin
            write_reg(fcfc_pkg::REG_WIDE, $urandom_range(0, 1));
            cnt = counts[$urandom_range(0, 5)];
            if (items > 1000) cnt = 12;
            write_reg(fcfc_pkg::REG_COUNT, cnt);
            rx_random = ($urandom & 3) != 0;
            clear_image(cnt);
            for (int k = 0; k < 10; k++) begin
                case ($urandom_range(0, 9))
                    0: pending_reqs.push_back(mk_req(fcfc_pkg::KIND_SCAN, $urandom, $urandom,
                                                     $urandom));
                    1: begin
                        r = mk_req(fcfc_pkg::KIND_LOAD, $urandom_range(0, 16383), $urandom,
                                   $urandom);
                        if (r.byte_addr >= (mdl_wide ? 2 * cnt + 2 : (3 * cnt) / 2 + 2))
                            pending_reqs.push_back(r);
                    end
                    2: pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, $urandom, $urandom,
                                                     $urandom_range(0, 3) == 0 ? $urandom
                                                     : $urandom_range(0, cnt + 2)));
                    3: begin
                        st = $urandom_range(2, cnt - 1);
                        set_entry(st, rand_entry(cnt));
                    end
                    4: pending_reqs.push_back(mk_req(fcfc_pkg::KIND_NONE, $urandom, $urandom,
                                                     $urandom));
                    default: begin
                        build_chain(cnt, st);
                        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_CHAIN, $urandom,
                                                      $urandom, st));
                    end
                endcase
            end
            pending_reqs.push_back(mk_req(fcfc_pkg::KIND_SCAN, 0, 0, 0));
            items += pending_reqs.size();
            wait_drained();
        end

        // extreme count written in wide mode, then count 3 and a single scan
        write_reg(fcfc_pkg::REG_WIDE, 1);
        write_reg(fcfc_pkg::REG_COUNT, 16'hffff);
        write_reg(fcfc_pkg::REG_COUNT, 3);
        pending_reqs.push_back(mk_req(fcfc_pkg::KIND_SCAN, 0, 0, 0));
        wait_drained();

        $display("covered %0d loads, %0d chain checks, %0d scans", n_loads, n_chains, n_scans);
        if (n_errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
